// ----- design/scds_pkg.sv -----
// shared types and constants for the serial clock divider solver
package scds_pkg;

    localparam int HZ_W       = 28;
    localparam int PRE_OUT_W  = 13;
    localparam int CNT_OUT_W  = 6;
    localparam int HIGH_OUT_W = 5;
    localparam int PRE_SCALE  = 4 + 1;

    localparam logic [HZ_W-1:0] SRC_RESET = HZ_W'(80000000);

    // one queued request, already classified by the front part
    typedef struct packed {
        logic            bypass;
        logic [HZ_W-1:0] req;
    } req_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_PRE,
        ST_MUL_CNT,
        ST_DIV_CNT,
        ST_MUL_ACH,
        ST_DIV_ACH,
        ST_DONE
    } back_state_t;

endpackage

// ----- design/spi_clock_divider_solver_core.sv -----
// top level of the serial clock divider solver
//
// request channel: requested_hz with req_valid / req_stall, taken on a clock
// edge with req_valid high and req_stall low. result channel: divider
// settings and achieved_hz with res_valid / res_stall, same rule.
// source_clock_hz is written on any edge with cfg_write_en high; change it
// only while no request is in flight.
// requests land in a two-entry queue; the solver drains it one at a time.
// a divided request runs up to three 28-step divisions on one shared divider;
// a request of zero runs only the last one, for the achieved rate.
// a request above half the source clock skips the divider.
// the result sits in an output register; while it is stalled the solver
// finishes the next request and the queue keeps taking new ones until full.
// reset empties the queue, drops any pending result and sets the source
// clock to 80 MHz.
module spi_clock_divider_solver_core
    import scds_pkg::*;
#(
    parameter int PRE_DIV_MAX   = 8191,
    parameter int COUNT_DIV_MAX = 63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [HZ_W-1:0]       source_clock_hz,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [HZ_W-1:0]       requested_hz,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  use_source_clock,
    output logic [PRE_OUT_W-1:0]  pre_divider,
    output logic [CNT_OUT_W-1:0]  count_divider,
    output logic [HIGH_OUT_W-1:0] count_high,
    output logic [CNT_OUT_W-1:0]  count_low,
    output logic [HZ_W-1:0]       achieved_hz
);

    logic [HZ_W-1:0] src_reg;
    queue_status_t   q_status;
    req_entry_t      push_entry;
    req_entry_t      pop_entry;
    logic            push;
    logic            pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= SRC_RESET;
        end
        else if (cfg_write_en)
        begin
            src_reg <= source_clock_hz;
        end
    end

    scds_front u_front (
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .requested_hz (requested_hz),
        .src          (src_reg),
        .q_status     (q_status),
        .push         (push),
        .entry        (push_entry)
    );

    scds_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (push_entry),
        .pop       (pop),
        .entry_out (pop_entry),
        .status    (q_status)
    );

    scds_back #(
        .PRE_DIV_MAX   (PRE_DIV_MAX),
        .COUNT_DIV_MAX (COUNT_DIV_MAX)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .src              (src_reg),
        .q_status         (q_status),
        .entry            (pop_entry),
        .pop              (pop),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .use_source_clock (use_source_clock),
        .pre_divider      (pre_divider),
        .count_divider    (count_divider),
        .count_high       (count_high),
        .count_low        (count_low),
        .achieved_hz      (achieved_hz)
    );

endmodule

// ----- design/scds_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module scds_div
    import scds_pkg::*;
#(
    parameter int DEN_W = 45
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [HZ_W-1:0]  num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [HZ_W-1:0]  quot
);

    localparam int STEP_W = $clog2(HZ_W + 1);

    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [HZ_W-1:0]   shift_reg;
    logic [DEN_W:0]    rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg, shift_reg[HZ_W-1]};
    assign fits      = rem_shift >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= STEP_W'(HZ_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            shift_reg <= num;
        end
        else if (step_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(rem_shift - {1'b0, den});
            end
            else
            begin
                rem_reg <= rem_shift[DEN_W-1:0];
            end
            shift_reg <= {shift_reg[HZ_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = shift_reg;

endmodule

// ----- design/scds_fifo.sv -----
// two-entry request queue between front and back
module scds_fifo
    import scds_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  req_entry_t    entry_in,
    input  logic          pop,
    output req_entry_t    entry_out,
    output queue_status_t status
);

    localparam int DEPTH = 2;

    req_entry_t       mem [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry_in;
        end
    end

    assign entry_out    = mem[rd_ptr_reg];
    assign status.full  = fill_reg == 2'(DEPTH);
    assign status.empty = fill_reg == '0;

endmodule

// ----- design/scds_front.sv -----
// front part: takes requests and flags the ones that bypass the divider
module scds_front
    import scds_pkg::*;
(
    input  logic            req_valid,
    output logic            req_stall,
    input  logic [HZ_W-1:0] requested_hz,
    input  logic [HZ_W-1:0] src,
    input  queue_status_t   q_status,
    output logic            push,
    output req_entry_t      entry
);

    assign req_stall    = q_status.full;
    assign push         = req_valid && !q_status.full;
    // more than half the source clock goes straight through
    assign entry.bypass = requested_hz > (src >> 1);
    assign entry.req    = requested_hz;

endmodule

// ----- design/scds_back.sv -----
// back part: solves prescaler, counter and achieved rate with a shared divider
module scds_back
    import scds_pkg::*;
#(
    parameter int PRE_DIV_MAX   = 8191,
    parameter int COUNT_DIV_MAX = 63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [HZ_W-1:0]       src,
    input  queue_status_t         q_status,
    input  req_entry_t            entry,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  use_source_clock,
    output logic [PRE_OUT_W-1:0]  pre_divider,
    output logic [CNT_OUT_W-1:0]  count_divider,
    output logic [HIGH_OUT_W-1:0] count_high,
    output logic [CNT_OUT_W-1:0]  count_low,
    output logic [HZ_W-1:0]       achieved_hz
);

    localparam int PRE_W = $clog2(PRE_DIV_MAX + 1);
    localparam int CNT_W = $clog2(COUNT_DIV_MAX + 1);
    localparam int PP_W  = PRE_W + 1;
    localparam int CP_W  = CNT_W + 1;
    localparam int DEN_W = (PP_W + HZ_W > HZ_W + 3) ? PP_W + HZ_W : HZ_W + 3;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             load_out;
    logic             div_start_reg;
    logic             div_start_next;
    logic             div_done;
    logic [HZ_W-1:0]  div_quot;

    logic [HZ_W-1:0]  req_reg;
    logic             byp_reg;
    logic [PRE_W-1:0] pre_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [HZ_W-1:0]  ach_reg;
    logic [DEN_W-1:0] den_reg;

    logic             out_valid_reg;
    logic             out_byp_reg;
    logic [PRE_OUT_W-1:0]  out_pre_reg;
    logic [CNT_OUT_W-1:0]  out_cnt_reg;
    logic [HIGH_OUT_W-1:0] out_high_reg;
    logic [HZ_W-1:0]  out_ach_reg;
    logic [HZ_W-1:0]  out_src_reg;

    logic [PP_W-1:0]        pre_plus;
    logic [CP_W-1:0]        cnt_plus;
    logic [CP_W-1:0]        high_val;
    logic [HZ_W+2:0]        den_pre;
    logic [PP_W+HZ_W-1:0]   den_cnt;
    logic [PP_W+CP_W-1:0]   den_ach;

    // quotient minus one, held at zero below and at the limit above
    function automatic logic [PRE_W-1:0] clamp_pre(input logic [HZ_W-1:0] q);
        logic [HZ_W-1:0] qm;
        qm = (q == '0) ? '0 : q - HZ_W'(1);
        if (32'(qm) > 32'(PRE_DIV_MAX))
            return PRE_W'(PRE_DIV_MAX);
        return qm[PRE_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [HZ_W-1:0] q);
        logic [HZ_W-1:0] qm;
        qm = (q == '0) ? '0 : q - HZ_W'(1);
        if (32'(qm) > 32'(COUNT_DIV_MAX))
            return CNT_W'(COUNT_DIV_MAX);
        return qm[CNT_W-1:0];
    endfunction

    assign pre_plus = PP_W'(pre_reg) + PP_W'(1);
    assign cnt_plus = CP_W'(cnt_reg) + CP_W'(1);
    assign high_val = (cnt_reg == '0) ? '0 : (cnt_plus >> 1) - CP_W'(1);
    assign den_pre  = {3'b000, entry.req} + {1'b0, entry.req, 2'b00};
    assign den_cnt  = pre_plus * req_reg;
    assign den_ach  = pre_plus * cnt_plus;

    scds_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (src),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        div_start_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (entry.bypass)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (entry.req == '0)
                    begin
                        // no rate asked for: both stages at their limit
                        state_next = ST_MUL_ACH;
                    end
                    else
                    begin
                        state_next     = ST_DIV_PRE;
                        div_start_next = 1'b1;
                    end
                end
            end
            ST_DIV_PRE:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_CNT;
                end
            end
            ST_MUL_CNT:
            begin
                state_next     = ST_DIV_CNT;
                div_start_next = 1'b1;
            end
            ST_DIV_CNT:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_ACH;
                end
            end
            ST_MUL_ACH:
            begin
                state_next     = ST_DIV_ACH;
                div_start_next = 1'b1;
            end
            ST_DIV_ACH:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    req_reg <= entry.req;
                    byp_reg <= entry.bypass;
                    ach_reg <= src;
                    den_reg <= DEN_W'(den_pre);
                    if (entry.bypass)
                    begin
                        pre_reg <= '0;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        pre_reg <= PRE_W'(PRE_DIV_MAX);
                        cnt_reg <= CNT_W'(COUNT_DIV_MAX);
                    end
                end
            end
            ST_DIV_PRE:
            begin
                if (div_done)
                begin
                    pre_reg <= clamp_pre(div_quot);
                end
            end
            ST_MUL_CNT:
            begin
                den_reg <= DEN_W'(den_cnt);
            end
            ST_DIV_CNT:
            begin
                if (div_done)
                begin
                    cnt_reg <= clamp_cnt(div_quot);
                end
            end
            ST_MUL_ACH:
            begin
                den_reg <= DEN_W'(den_ach);
            end
            ST_DIV_ACH:
            begin
                if (div_done)
                begin
                    ach_reg <= div_quot;
                end
            end
            default:
            begin
            end
        endcase

        if (load_out)
        begin
            out_byp_reg  <= byp_reg;
            out_pre_reg  <= PRE_OUT_W'(pre_reg);
            out_cnt_reg  <= CNT_OUT_W'(cnt_reg);
            out_high_reg <= HIGH_OUT_W'(high_val);
            out_ach_reg  <= ach_reg;
            out_src_reg  <= src;
        end
    end

    assign res_valid        = out_valid_reg;
    assign use_source_clock = out_byp_reg;
    assign pre_divider      = out_pre_reg;
    assign count_divider    = out_cnt_reg;
    assign count_high       = out_high_reg;
    assign count_low        = out_cnt_reg;
    assign achieved_hz      = out_ach_reg;

`ifndef SYNTHESIS
    a_bypass_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_byp_reg |->
            out_pre_reg == '0 && out_cnt_reg == '0 && out_high_reg == '0)
        else $error("bypass request left divider fields set");

    a_achieved_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_ach_reg <= out_src_reg)
        else $error("achieved rate above source clock");

    a_done_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_PRE || state_reg == ST_DIV_CNT
                     || state_reg == ST_DIV_ACH)
        else $error("divider finished outside a divide step");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> $past(state_reg) == ST_IDLE || $past(state_reg) == ST_MUL_CNT
                          || $past(state_reg) == ST_MUL_ACH)
        else $error("divider started from an unexpected step");
`endif

endmodule
